// ===== rtl/core/ptb_pkg.sv =====
package ptb_pkg;

  localparam int SLOT_W = 4;
  localparam int REP_W  = 24;
  localparam int TAG_W  = 16;
  localparam int INT_W  = 24;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

endpackage

// ===== rtl/core/periodic_ticker_bank_top.sv =====
// Periodic ticker bank.
// Input channel: a word is taken when start is high and busy is low.
//   in_op = load writes one entry (delay, period, repeat count, tag) in
//   the accepting cycle; busy stays low and no result follows. A load to
//   a slot at or above NUM_TICKERS is dropped.
//   in_op = tick sweeps all entries: busy is high through the sweep,
//   one read-modify-write of the entry memory per cycle, and through
//   the drain state that empties the read pipeline.
// Result channel: out_valid strobes one word per fired entry, in index
//   order, for exactly one cycle each. A firing is held back until the
//   next one or the tick's end so that out_last_fire can mark the final
//   word; it leaves via the flush and output registers after busy falls.
//   A tick that fires nothing gives no word. The receiver cannot stall
//   the block; none is needed, as at most one word comes per cycle.
// Reset (rst_n low, synchronous) returns the sweep to idle and marks all
//   entries idle at once; no clearing pass is needed.
module periodic_ticker_bank_top
  import ptb_pkg::*;
#(
  parameter int NUM_TICKERS = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_op,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic [INT_W-1:0]        in_start_delay,
  input  logic [INT_W-1:0]        in_reload_period,
  input  logic signed [REP_W-1:0] in_repeats,
  input  logic [TAG_W-1:0]        in_payload_tag,
  output logic                    out_valid,
  output logic [SLOT_W-1:0]       out_fired_slot,
  output logic [TAG_W-1:0]        out_fired_tag,
  output logic                    out_last_fire
);

  localparam int IDX_W = (NUM_TICKERS > 1) ? $clog2(NUM_TICKERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TICKERS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]     s1_idx_r, s1_idx_nxt;
  logic                 flush_r, flush_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic [TAG_W-1:0]     pend_tag_r, pend_tag_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                    accept;
  logic                    load_go;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [TIME_BITS-1:0]    wr_delay;
  logic [TIME_BITS-1:0]    wr_period;
  logic signed [REP_W-1:0] wr_rep;
  logic [TAG_W-1:0]        wr_tag;
  logic [TIME_BITS-1:0]    rd_delay;
  logic [TIME_BITS-1:0]    rd_period;
  logic signed [REP_W-1:0] rd_rep;
  logic [TAG_W-1:0]        rd_tag;
  logic [TIME_BITS-1:0]    upd_delay;
  logic signed [REP_W-1:0] upd_rep;
  logic                    upd_fire;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign load_go = accept && (in_op == OP_LOAD) && (32'(in_slot) < NUM_TICKERS);

  ptb_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .cur_delay  (rd_delay),
    .cur_period (rd_period),
    .cur_rep    (rd_rep),
    .nxt_delay  (upd_delay),
    .nxt_rep    (upd_rep),
    .fire       (upd_fire)
  );

  // single write port: loads only while idle, write-back only during sweep and drain
  always_comb begin
    wr_en     = load_go || s1_vld_r;
    wr_idx    = s1_idx_r;
    wr_delay  = upd_delay;
    wr_period = rd_period;
    wr_rep    = upd_rep;
    wr_tag    = rd_tag;
    if (!s1_vld_r) begin
      wr_idx    = IDX_W'(in_slot);
      wr_delay  = TIME_BITS'(in_start_delay);
      wr_period = TIME_BITS'(in_reload_period);
      wr_rep    = in_repeats;
      wr_tag    = in_payload_tag;
    end
  end

  ptb_store #(
    .NUM_TICKERS (NUM_TICKERS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_delay  (wr_delay),
    .wr_period (wr_period),
    .wr_rep    (wr_rep),
    .wr_tag    (wr_tag),
    .rd_en     (state_r == ST_SWEEP),
    .rd_idx    (rd_idx_r),
    .rd_delay  (rd_delay),
    .rd_period (rd_period),
    .rd_rep    (rd_rep),
    .rd_tag    (rd_tag)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    s1_vld_nxt    = 1'b0;
    s1_idx_nxt    = s1_idx_r;
    flush_nxt     = 1'b0;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    pend_tag_nxt  = pend_tag_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_TICK)) begin
          state_nxt  = ST_SWEEP;
          rd_idx_nxt = '0;
        end
      end
      ST_SWEEP: begin
        s1_vld_nxt = 1'b1;
        s1_idx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
        flush_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a new firing releases the held one as not-last
    if (s1_vld_r && upd_fire) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = pend_slot_r;
        out_tag_nxt   = pend_tag_r;
      end
      pend_vld_nxt  = 1'b1;
      pend_slot_nxt = SLOT_W'(s1_idx_r);
      pend_tag_nxt  = rd_tag;
    end

    if (flush_r && pend_vld_r) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = pend_slot_r;
      out_tag_nxt   = pend_tag_r;
      out_last_nxt  = 1'b1;
      pend_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_vld_r    <= 1'b0;
      flush_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_vld_r    <= s1_vld_nxt;
      flush_r     <= flush_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    rd_idx_r    <= rd_idx_nxt;
    s1_idx_r    <= s1_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_tag_r  <= pend_tag_nxt;
    out_slot_r  <= out_slot_nxt;
    out_tag_r   <= out_tag_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired_slot = out_slot_r;
  assign out_fired_tag  = out_tag_r;
  assign out_last_fire  = out_last_r;

`ifndef SYNTHESIS
  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (state_r == ST_IDLE))
    else $error("flush outside idle");

  a_s1_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (state_r != ST_IDLE))
    else $error("entry update while idle");

  a_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !flush_r) |-> !pend_vld_r)
    else $error("held firing left after tick");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_LOAD) |=> !busy)
    else $error("load raised busy");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_TICK) |=> (state_r == ST_SWEEP && rd_idx_r == '0))
    else $error("tick did not start sweep");
`endif

endmodule

// ===== rtl/core/ptb_store.sv =====
module ptb_store
  import ptb_pkg::*;
#(
  parameter int NUM_TICKERS = 16,
  parameter int TIME_BITS   = 24,
  parameter int IDX_W       = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_idx,
  input  logic [TIME_BITS-1:0]    wr_delay,
  input  logic [TIME_BITS-1:0]    wr_period,
  input  logic signed [REP_W-1:0] wr_rep,
  input  logic [TAG_W-1:0]        wr_tag,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic [TIME_BITS-1:0]    rd_delay,
  output logic [TIME_BITS-1:0]    rd_period,
  output logic signed [REP_W-1:0] rd_rep,
  output logic [TAG_W-1:0]        rd_tag
);

  localparam int ENT_W = 2 * TIME_BITS + REP_W + TAG_W;

  logic [ENT_W-1:0]       mem_r [NUM_TICKERS];
  logic [NUM_TICKERS-1:0] valid_r;
  logic [ENT_W-1:0]       rd_data_r;
  logic                   rd_vld_r;
  logic [ENT_W-1:0]       rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= {wr_delay, wr_period, wr_rep, wr_tag};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  // never-written entries read as zero (idle)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r : '0;

  assign {rd_delay, rd_period, rd_rep, rd_tag} = rd_word;

endmodule

// ===== rtl/core/ptb_update.sv =====
module ptb_update
  import ptb_pkg::*;
#(
  parameter int TIME_BITS = 24
) (
  input  logic [TIME_BITS-1:0]    cur_delay,
  input  logic [TIME_BITS-1:0]    cur_period,
  input  logic signed [REP_W-1:0] cur_rep,
  output logic [TIME_BITS-1:0]    nxt_delay,
  output logic signed [REP_W-1:0] nxt_rep,
  output logic                    fire
);

  logic [TIME_BITS-1:0]    dec;
  logic signed [REP_W-1:0] rep_dec;

  always_comb begin
    dec       = cur_delay - TIME_BITS'(1);
    rep_dec   = cur_rep - REP_W'(1);
    nxt_delay = cur_delay;
    nxt_rep   = cur_rep;
    fire      = 1'b0;
    if (cur_delay != '0) begin
      nxt_delay = dec;
      if (dec == '0) begin
        fire = 1'b1;
        if (cur_rep != '0) begin
          nxt_delay = cur_period;
          if (!cur_rep[REP_W-1]) begin
            nxt_rep = rep_dec;
          end
        end
      end
    end
  end

endmodule
